@@ rtl/core/fisa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fisa_pkg;

    localparam int TIME_W    = 32;
    localparam int BTYPE_W   = 4;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam int unsigned FREE = 0;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FREE_TYPE  = 2'd1,
        ST_NOT_INSIDE = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_STOP  = 1'b1;

    typedef struct packed {
        logic candidate;
        logic fits;
        logic same_b;
        logic same_e;
    } cmp_t;

endpackage

`default_nettype wire

@@ rtl/core/fisa_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fisa_in_if;
    logic                          valid;
    logic                          ready;
    logic [fisa_pkg::TIME_W-1:0]  start_time;
    logic [fisa_pkg::TIME_W-1:0]  stop_time;
    logic [fisa_pkg::BTYPE_W-1:0] booking_type;

    modport source (output valid, start_time, stop_time, booking_type, input ready);
    modport sink (input valid, start_time, stop_time, booking_type, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fisa_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fisa_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [fisa_pkg::SLOT_W-1:0]  slot_index;
    logic [fisa_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, status, slot_index, entry_count, input ready);
    modport sink (input valid, status, slot_index, entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fisa_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fisa_cmp import fisa_pkg::*;
(
    input  logic [TIME_W-1:0] req_begin,
    input  logic [TIME_W-1:0] req_end,
    input  logic [TIME_W-1:0] ent_begin,
    input  logic [TIME_W-1:0] ent_end,
    input  logic              ent_free,
    output cmp_t              res
);

    always_comb
    begin
        res.candidate = ent_free && (req_begin <= ent_end);
        res.fits      = (req_begin >= ent_begin) && (req_end <= ent_end)
                        && (req_begin != ent_end);
        res.same_b    = (req_begin == ent_begin);
        res.same_e    = (req_end == ent_end);
    end

endmodule

`default_nettype wire

@@ rtl/core/free_interval_splitting_allocator.sv @@
// Channel | Dir | Payload                              | Transfer
// req     | in  | start_time, stop_time, booking_type  | valid & ready
// rsp     | out | status, slot_index, entry_count      | valid & ready
// cfg     | in  | cfg_index, cfg_data                  | cfg_we, no handshake
//
// A booking is worked through before the next request transfer is taken: the shared
// compare unit walks the table from entry 0 to the free slot, one entry per cycle, and
// the memory port then moves the later entries up one per cycle before up to three
// entries are written.
// A free booking type is refused without a table scan.
// After reset, and after every configuration write, the S_INIT state writes the initial entry.
// The result waits in an output register, so a stalled consumer only blocks the end of
// the following booking.
`timescale 1ns / 1ps
`default_nettype none

module free_interval_splitting_allocator import fisa_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int TYPE_BITS   = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    fisa_in_if.sink                   req,
    fisa_out_if.source                rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_PLAN  = 9'b000001000,
        S_SHIFT = 9'b000010000,
        S_HEAD  = 9'b000100000,
        S_MID   = 9'b001000000,
        S_TAIL  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    logic [TIME_W-1:0]    mem_begin [MAX_ENTRIES];
    logic [TIME_W-1:0]    mem_end   [MAX_ENTRIES];
    logic [TYPE_BITS-1:0] mem_kind  [MAX_ENTRIES];

    state_t               state_reg, state_next;
    logic [TIME_W-1:0]    span_start_reg, span_start_next;
    logic [TIME_W-1:0]    span_stop_reg, span_stop_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [TIME_W-1:0]    rb_reg, rb_next;
    logic [TIME_W-1:0]    re_reg, re_next;
    logic [TYPE_BITS-1:0] rt_reg, rt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     wa_reg, wa_next;
    logic [IDX_W-1:0]     p_reg, p_next;
    logic [IDX_W-1:0]     wp_reg, wp_next;
    logic [TIME_W-1:0]    fb_reg, fb_next;
    logic [TIME_W-1:0]    fe_reg, fe_next;
    logic                 same_b_reg, same_b_next;
    logic                 same_e_reg, same_e_next;
    logic [1:0]           need_reg, need_next;
    status_t              res_status_reg, res_status_next;
    logic [IDX_W-1:0]     res_slot_reg, res_slot_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    logic [TIME_W-1:0]    rd_begin_reg;
    logic [TIME_W-1:0]    rd_end_reg;
    logic [TYPE_BITS-1:0] rd_kind_reg;

    logic [CNT_W-1:0]     raddr_full;
    logic [IDX_W-1:0]     raddr;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [TIME_W-1:0]    wbegin;
    logic [TIME_W-1:0]    wend;
    logic [TYPE_BITS-1:0] wkind;

    logic [TYPE_BITS-1:0] rt_in;
    cmp_t                 cmp;
    logic [1:0]           need;
    logic [CNT_W:0]       used_plus;
    logic [CNT_W-1:0]     idx_dec;

    if (TYPE_BITS >= BTYPE_W)
    begin : g_type_wide
        assign rt_in = TYPE_BITS'(req.booking_type);
    end
    else
    begin : g_type_narrow
        assign rt_in = req.booking_type[TYPE_BITS-1:0];
    end

    fisa_cmp u_fisa_cmp
    (
        .req_begin (rb_reg),
        .req_end   (re_reg),
        .ent_begin (rd_begin_reg),
        .ent_end   (rd_end_reg),
        .ent_free  (rd_kind_reg == TYPE_BITS'(FREE)),
        .res       (cmp)
    );

    assign need      = 2'(!same_b_reg) + 2'(!same_e_reg);
    assign used_plus = {1'b0, used_reg} + (CNT_W + 1)'(need);
    assign idx_dec   = idx_reg - CNT_W'(1);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.entry_count = out_count_reg;

    always_comb
    begin
        raddr_full = (state_reg == S_SHIFT) ? idx_dec : idx_reg;
        raddr      = raddr_full[IDX_W-1:0];
    end

    always_comb
    begin
        we     = 1'b0;
        waddr  = wp_reg;
        wbegin = rb_reg;
        wend   = re_reg;
        wkind  = rt_reg;
        unique case (state_reg)
            S_INIT:
            begin
                we     = 1'b1;
                waddr  = '0;
                wbegin = span_start_reg;
                wend   = span_stop_reg;
                wkind  = TYPE_BITS'(FREE);
            end
            S_SHIFT:
            begin
                we     = pend_reg;
                waddr  = wa_reg;
                wbegin = rd_begin_reg;
                wend   = rd_end_reg;
                wkind  = rd_kind_reg;
            end
            S_HEAD:
            begin
                we     = 1'b1;
                wbegin = fb_reg;
                wend   = rb_reg;
                wkind  = TYPE_BITS'(FREE);
            end
            S_MID:
            begin
                we = 1'b1;
            end
            S_TAIL:
            begin
                we     = 1'b1;
                wbegin = re_reg;
                wend   = fe_reg;
                wkind  = TYPE_BITS'(FREE);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_begin[waddr] <= wbegin;
            mem_end[waddr]   <= wend;
            mem_kind[waddr]  <= wkind;
        end
        rd_begin_reg <= mem_begin[raddr];
        rd_end_reg   <= mem_end[raddr];
        rd_kind_reg  <= mem_kind[raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        span_start_next = span_start_reg;
        span_stop_next  = span_stop_reg;
        used_next       = used_reg;
        rb_next         = rb_reg;
        re_next         = re_reg;
        rt_next         = rt_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        wa_next         = wa_reg;
        p_next          = p_reg;
        wp_next         = wp_reg;
        fb_next         = fb_reg;
        fe_next         = fe_reg;
        same_b_next     = same_b_reg;
        same_e_next     = same_e_reg;
        need_next       = need_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;

        unique case (state_reg)
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rb_next       = req.start_time;
                    re_next       = req.stop_time;
                    rt_next       = rt_in;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    res_slot_next = '0;
                    if (rt_in == TYPE_BITS'(FREE))
                    begin
                        res_status_next = ST_FREE_TYPE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && cmp.candidate)
                begin
                    pend_next = 1'b0;
                    if (cmp.fits)
                    begin
                        p_next      = idx_dec[IDX_W-1:0];
                        fb_next     = rd_begin_reg;
                        fe_next     = rd_end_reg;
                        same_b_next = cmp.same_b;
                        same_e_next = cmp.same_e;
                        state_next  = S_PLAN;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_INSIDE;
                        state_next      = S_DONE;
                    end
                end
                else if (!pend_reg && (idx_reg >= used_reg))
                begin
                    res_status_next = ST_NOT_INSIDE;
                    state_next      = S_DONE;
                end
                else if (idx_reg < used_reg)
                begin
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_PLAN:
            begin
                wp_next = p_reg;
                if (used_plus > (CNT_W + 1)'(MAX_ENTRIES))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = p_reg;
                    used_next       = used_plus[CNT_W-1:0];
                    need_next       = need;
                    idx_next        = used_reg;
                    pend_next       = 1'b0;
                    state_next      = (need == 2'd0) ? S_MID : S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (idx_reg > CNT_W'(p_reg))
                begin
                    wa_next   = IDX_W'(idx_dec + CNT_W'(need_reg));
                    idx_next  = idx_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = same_b_reg ? S_MID : S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                wp_next    = wp_reg + IDX_W'(1);
                state_next = S_MID;
            end
            S_MID:
            begin
                wp_next    = wp_reg + IDX_W'(1);
                state_next = same_e_reg ? S_DONE : S_TAIL;
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = (res_status_reg == ST_OK) ?
                                      SLOT_W'(res_slot_reg) : '0;
                    out_count_next  = COUNT_W'(used_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPAN_START: span_start_next = cfg_data[TIME_W-1:0];
                CFG_SPAN_STOP:  span_stop_next  = cfg_data[TIME_W-1:0];
                default:        span_start_next = span_start_reg;
            endcase
            used_next  = CNT_W'(1);
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            span_start_reg <= '0;
            span_stop_reg  <= '1;
            used_reg       <= CNT_W'(1);
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            span_start_reg <= span_start_next;
            span_stop_reg  <= span_stop_next;
            used_reg       <= used_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rb_reg         <= rb_next;
        re_reg         <= re_next;
        rt_reg         <= rt_next;
        idx_reg        <= idx_next;
        wa_reg         <= wa_next;
        p_reg          <= p_next;
        wp_reg         <= wp_next;
        fb_reg         <= fb_next;
        fe_reg         <= fe_next;
        same_b_reg     <= same_b_next;
        same_e_reg     <= same_e_next;
        need_reg       <= need_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/fisa_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fisa_chk import fisa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    fisa_in_if.sink    req,
    fisa_out_if.source rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
        && $stable(rsp.slot_index) && $stable(rsp.entry_count))
        else $error("result changed while stalled");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> (rsp.slot_index == '0))
        else $error("slot index set on a refused booking");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while a booking is in progress");

    a_cfg_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !req.ready)
        else $error("request taken before the table was rebuilt");

endmodule

bind free_interval_splitting_allocator fisa_chk u_fisa_chk
(
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .req    (req),
    .rsp    (rsp)
);

`default_nettype wire

@@ tb/sv/free_interval_splitting_allocator_tb.sv @@
`timescale 1ns / 1ps

module free_interval_splitting_allocator_tb;
    import fisa_pkg::*;

    localparam int TBL_DEPTH      = 64;
    localparam int CLK_HALF       = 4;
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int BOOKING_TARGET = 1700;
    localparam int IDLE_PCT       = 38;
    localparam int SETTLE_CYCLES  = 80;
    localparam logic [BTYPE_W-1:0] KIND_FREE = BTYPE_W'(FREE);

    typedef logic [TIME_W-1:0] stamp_t;

    typedef struct {
        status_t              status;
        logic [SLOT_W-1:0]    slot_index;
        logic [COUNT_W-1:0]   entry_count;
    } booking_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    fisa_in_if  booking_if ();
    fisa_out_if result_if ();

    stamp_t             tbl_lo [TBL_DEPTH];
    stamp_t             tbl_hi [TBL_DEPTH];
    logic [BTYPE_W-1:0] tbl_kind [TBL_DEPTH];
    int                 tbl_used;
    stamp_t             span_lo;
    stamp_t             span_hi;

    booking_result_t pending_q [$];
    int              mismatch_count = 0;
    int              bookings_sent  = 0;
    int              idle_pct       = IDLE_PCT;
    longint          cycle_count    = 0;

    free_interval_splitting_allocator #(
        .MAX_ENTRIES (TBL_DEPTH),
        .TYPE_BITS   (BTYPE_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (booking_if),
        .rsp       (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void reset_table();
        tbl_lo[0]   = span_lo;
        tbl_hi[0]   = span_hi;
        tbl_kind[0] = KIND_FREE;
        tbl_used    = 1;
    endfunction

    function automatic void open_slots(int p, int k);
        for (int i = tbl_used - 1; i >= p; i--)
        begin
            tbl_lo[i + k]   = tbl_lo[i];
            tbl_hi[i + k]   = tbl_hi[i];
            tbl_kind[i + k] = tbl_kind[i];
        end
        tbl_used += k;
    endfunction

    function automatic void put_entry(int p, stamp_t lo, stamp_t hi, logic [BTYPE_W-1:0] kind);
        tbl_lo[p]   = lo;
        tbl_hi[p]   = hi;
        tbl_kind[p] = kind;
    endfunction

    function automatic booking_result_t book_interval(stamp_t rb, stamp_t re,
                                                      logic [BTYPE_W-1:0] kind);
        booking_result_t res;
        int              p;
        int              need;
        bit              found;
        bit              same_b;
        bit              same_e;
        stamp_t          fb;
        stamp_t          fe;
        res.status     = ST_OK;
        res.slot_index = '0;
        found          = 1'b0;
        p              = 0;
        if (kind == KIND_FREE)
        begin
            res.status = ST_FREE_TYPE;
        end
        else
        begin
            // Only the first free entry that does not end before the request counts.
            for (int i = 0; i < tbl_used; i++)
            begin
                if (tbl_kind[i] == KIND_FREE && rb <= tbl_hi[i])
                begin
                    found = (rb >= tbl_lo[i]) && (re <= tbl_hi[i]) && (rb != tbl_hi[i]);
                    p     = i;
                    break;
                end
            end
            if (!found)
            begin
                res.status = ST_NOT_INSIDE;
            end
            else
            begin
                fb     = tbl_lo[p];
                fe     = tbl_hi[p];
                same_b = (rb == fb);
                same_e = (re == fe);
                need   = (same_b && same_e) ? 0 : ((same_b || same_e) ? 1 : 2);
                if (tbl_used + need > TBL_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    res.slot_index = SLOT_W'(p);
                    if (same_b && same_e)
                    begin
                        tbl_kind[p] = kind;
                    end
                    else if (same_b)
                    begin
                        open_slots(p, 1);
                        put_entry(p, rb, re, kind);
                        tbl_lo[p + 1] = re;
                    end
                    else if (same_e)
                    begin
                        open_slots(p, 1);
                        put_entry(p, fb, rb, KIND_FREE);
                        put_entry(p + 1, rb, fe, kind);
                    end
                    else
                    begin
                        open_slots(p, 2);
                        put_entry(p, fb, rb, KIND_FREE);
                        put_entry(p + 1, rb, re, kind);
                        tbl_lo[p + 2] = re;
                    end
                end
            end
        end
        res.entry_count = COUNT_W'(tbl_used);
        return res;
    endfunction

    task automatic send_booking(stamp_t rb, stamp_t re, logic [BTYPE_W-1:0] kind);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            booking_if.valid <= 1'b0;
            @(posedge clk);
        end
        booking_if.valid        <= 1'b1;
        booking_if.start_time   <= rb;
        booking_if.stop_time    <= re;
        booking_if.booking_type <= kind;
        @(posedge clk);
        while (booking_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        pending_q.push_back(book_interval(rb, re, kind));
        bookings_sent++;
    endtask

    task automatic send_random_booking(int noise_pct);
        int                 free_idx [$];
        int                 k;
        int                 roll;
        stamp_t             lo;
        stamp_t             hi;
        stamp_t             rb;
        stamp_t             re;
        logic [BTYPE_W-1:0] kind;
        logic [63:0]        room;
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_kind[i] == KIND_FREE && tbl_hi[i] > tbl_lo[i])
            begin
                free_idx.push_back(i);
            end
        end
        if (free_idx.size() == 0 || $urandom_range(0, 99) < noise_pct)
        begin
            rb   = $urandom();
            re   = $urandom();
            kind = BTYPE_W'($urandom());
        end
        else
        begin
            k    = free_idx[$urandom_range(0, free_idx.size() - 1)];
            lo   = tbl_lo[k];
            hi   = tbl_hi[k];
            rb   = ($urandom_range(0, 3) == 0) ? lo : lo + ($urandom() % (hi - lo));
            room = {32'd0, hi} - {32'd0, rb} + 64'd1;
            roll = $urandom_range(0, 99);
            if (roll < 25)
                re = hi;
            else if (roll < 33)
                re = rb;
            else if (roll < 38)
                re = rb - stamp_t'($urandom_range(1, 1000));
            else if (roll < 42)
                re = hi + stamp_t'($urandom_range(1, 1000));
            else
                re = rb + stamp_t'({32'd0, $urandom()} % room);
            kind = BTYPE_W'($urandom_range(1, (1 << BTYPE_W) - 1));
            if ($urandom_range(0, 19) == 0)
                kind = KIND_FREE;
        end
        send_booking(rb, re, kind);
    endtask

    task automatic wait_drained();
        booking_if.valid <= 1'b0;
        while (pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_span(logic [CFG_IDX_W-1:0] idx, stamp_t value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SPAN_START)
            span_lo = value;
        else
            span_hi = value;
        reset_table();
    endtask

    task automatic test_directed_cases();
        send_booking(32'd10, 32'd20, KIND_FREE);
        send_booking(32'd100, 32'd200, 4'd1);
        send_booking(32'd150, 32'd160, 4'd2);
        send_booking(32'd100, 32'd150, 4'd3);
        send_booking(32'd0, 32'd50, 4'd4);
        send_booking(32'd70, 32'd100, 4'd5);
        send_booking(32'd50, 32'd70, 4'd6);
        send_booking(32'hFFFF_FFFE, 32'hFFFF_FFFF, 4'hF);
        send_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1);
        send_booking(32'd300, 32'd300, 4'd2);
        send_booking(32'd500, 32'd400, 4'd3);
        send_booking(32'd0, 32'd1, 4'd8);
    endtask

    task automatic test_span_registers();
        write_span(CFG_SPAN_START, 32'd1000);
        write_span(CFG_SPAN_STOP, 32'd2000);
        send_booking(32'd500, 32'd1500, 4'd1);
        send_booking(32'd1500, 32'd2500, 4'd2);
        send_booking(32'd3000, 32'd3100, 4'd3);
        send_booking(32'd1000, 32'd2000, 4'd7);
        send_booking(32'd1000, 32'd2000, 4'd8);
        write_span(CFG_SPAN_STOP, 32'd1000);
        send_booking(32'd1000, 32'd1000, 4'd1);
        write_span(CFG_SPAN_START, 32'hFFFF_FFFF);
        send_booking(32'd5, 32'd5, 4'd1);
        send_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd2);
        write_span(CFG_SPAN_START, 32'd0);
        write_span(CFG_SPAN_STOP, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_to_capacity();
        int guard;
        guard = 0;
        while (tbl_used < TBL_DEPTH && guard < 400)
        begin
            send_random_booking(0);
            guard++;
        end
        repeat (16) send_random_booking(0);
    endtask

    task automatic test_random_phases();
        int     phase;
        int     len;
        stamp_t a;
        stamp_t b;
        phase = 0;
        while (bookings_sent < BOOKING_TARGET)
        begin
            a   = $urandom();
            b   = $urandom();
            len = $urandom_range(40, 90);
            case (phase % 6)
                0:
                begin
                    a = '0;
                    b = '1;
                end
                1:
                begin
                    if (a > b)
                        {a, b} = {b, a};
                end
                2: b = a + stamp_t'($urandom_range(1, 300));
                3:
                begin
                    b   = a;
                    len = 15;
                end
                4:
                begin
                    b   = a - stamp_t'($urandom_range(1, 300));
                    len = 15;
                end
                default:
                begin
                    a = stamp_t'($urandom_range(0, 1000));
                    b = '1 - stamp_t'($urandom_range(0, 1000));
                end
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_span(CFG_SPAN_START, a);
                write_span(CFG_SPAN_STOP, b);
            end
            else
            begin
                write_span(CFG_SPAN_STOP, b);
                write_span(CFG_SPAN_START, a);
            end
            if (phase == 7)
            begin
                idle_pct = 0;
                len      = 150;
            end
            else
            begin
                idle_pct = IDLE_PCT;
            end
            repeat (len) send_random_booking(12);
            phase++;
        end
        idle_pct = IDLE_PCT;
    endtask

    initial
    begin : result_checker
        booking_result_t want;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result transfer with no booking outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (result_if.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result_if.status);
                        mismatch_count++;
                    end
                    if (result_if.slot_index !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, result_if.slot_index);
                        mismatch_count++;
                    end
                    if (result_if.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, result_if.entry_count);
                        mismatch_count++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_SPAN_START;
        cfg_data                = '0;
        booking_if.valid        = 1'b0;
        booking_if.start_time   = '0;
        booking_if.stop_time    = '0;
        booking_if.booking_type = '0;
        span_lo                 = '0;
        span_hi                 = '1;
        reset_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_span_registers();
        test_fill_to_capacity();
        test_random_phases();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fisa_pkg.sv
rtl/core/fisa_in_if.sv
rtl/core/fisa_out_if.sv
rtl/core/fisa_cmp.sv
rtl/core/free_interval_splitting_allocator.sv
rtl/core/fisa_chk.sv
tb/sv/free_interval_splitting_allocator_tb.sv
